>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on i_clk, held off while i_rst_n is low.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on i_clk, held off while i_rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/stwsh_pkg.sv
`timescale 1ns / 1ps
package stwsh_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int TABLE_BITS  = 10;
    localparam int TAB_N       = 1 << TABLE_BITS;
    localparam int DATA_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    localparam int A_W      = 28;
    localparam int SQ_LAT   = A_W / 2;
    localparam int ROOT_W   = SQ_LAT;
    localparam int LANE_LAT = SQ_LAT + 7;

    localparam int GAIN_W = 26;
    localparam logic [GAIN_W-1:0] GAIN_CAP   = 26'd40960000;
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 26'd4096;

    localparam logic [2:0] REG_INPUT_GAIN  = 3'd0;
    localparam logic [2:0] REG_THRESHOLD   = 3'd1;
    localparam logic [2:0] REG_RATIO       = 3'd2;
    localparam logic [2:0] REG_SHAPE_MODE  = 3'd3;
    localparam logic [2:0] REG_BOOST_GAIN  = 3'd4;
    localparam logic [2:0] REG_OUTPUT_GAIN = 3'd5;

    localparam logic [2:0] MODE_CLIP   = 3'd0;
    localparam logic [2:0] MODE_LINEAR = 3'd1;
    localparam logic [2:0] MODE_QUAD   = 3'd2;
    localparam logic [2:0] MODE_SQRT   = 3'd3;
    localparam logic [2:0] MODE_SINE   = 3'd4;
    localparam logic [2:0] MODE_ERF    = 3'd5;

    typedef struct packed {
        logic [15:0] input_gain;
        logic [16:0] threshold_level;
        logic [15:0] ratio_level;
        logic [2:0]  shape_mode;
        logic [15:0] boost_gain;
        logic [15:0] output_gain;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV
    } t_gain_state;

    typedef logic signed [17:0] t_rom [TAB_N];

endpackage

>>> src/stwsh_gain.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stwsh_gain
    import stwsh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_we,
    output logic              o_busy,
    output logic [GAIN_W-1:0] o_gain
);

    t_gain_state r_state, n_state;
    logic signed [35:0] r_den;
    logic [35:0] r_rem;
    logic [40:0] r_quo;
    logic [5:0]  r_cnt;
    logic [GAIN_W-1:0] r_gain;

    logic signed [18:0] w_tcomp;
    logic signed [35:0] w_den;
    logic w_both_zero, w_special, w_prep, w_step;
    logic [35:0] w_shift;
    logic w_ge;
    logic [40:0] w_quo_n;

    assign w_tcomp = 19'sd65536 - $signed({2'b00, i_cfg.threshold_level});
    assign w_den = $signed({7'b0, i_cfg.threshold_level, 12'b0})
                 + $signed({20'b0, i_cfg.ratio_level}) * 36'(w_tcomp);
    assign w_both_zero = (i_cfg.threshold_level == 17'd0) && (i_cfg.ratio_level == 16'd0);
    assign w_special = w_both_zero || (w_den <= 36'sd0);

    assign w_shift = {r_rem[34:0], (r_cnt == 6'd40)};
    assign w_ge = w_shift >= $unsigned(r_den);
    assign w_quo_n = {r_quo[39:0], w_ge};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: n_state = ST_IDLE;
            ST_PREP: n_state = w_special ? ST_IDLE : ST_DIV;
            ST_DIV: n_state = (r_cnt == 6'd0) ? ST_IDLE : ST_DIV;
            default: n_state = ST_IDLE;
        endcase
        if (i_we) begin
            n_state = ST_PREP;
        end
    end

    always_comb begin
        o_busy = 1'b1;
        w_prep = 1'b0;
        w_step = 1'b0;
        case (r_state)
            ST_IDLE: o_busy = 1'b0;
            ST_PREP: w_prep = 1'b1;
            ST_DIV: w_step = 1'b1;
            default: o_busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_gain <= GAIN_UNITY;
            r_cnt <= 6'd0;
        end else begin
            r_state <= n_state;
            if (w_prep) begin
                r_den <= w_den;
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= 6'd40;
                if (w_both_zero) begin
                    r_gain <= GAIN_UNITY;
                end else if (w_den < 36'sd0) begin
                    r_gain <= '0;
                end else if (w_den == 36'sd0) begin
                    r_gain <= GAIN_CAP;
                end
            end else if (w_step) begin
                r_rem <= w_ge ? (w_shift - $unsigned(r_den)) : w_shift;
                r_quo <= w_quo_n;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_gain <= (w_quo_n > 41'(GAIN_CAP)) ? GAIN_CAP : w_quo_n[GAIN_W-1:0];
                end
            end
        end
    end

    assign o_gain = r_gain;

    `ASSERT_NEXT(a_gain_div_count, r_state == ST_DIV && r_cnt != 6'd0 && !i_we, r_state == ST_DIV && r_cnt == $past(r_cnt) - 6'd1, "gain divider lost its step count")
    `ASSERT_IMPL(a_gain_capped, 1'b1, r_gain <= GAIN_CAP, "makeup gain above cap")

endmodule

>>> src/stwsh_sqrt.sv
`timescale 1ns / 1ps
module stwsh_sqrt
    import stwsh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [A_W-1:0]    i_val,
    output logic [ROOT_W-1:0] o_root
);

    logic [A_W-1:0]    r_v    [SQ_LAT-1];
    logic [ROOT_W+1:0] r_rem  [SQ_LAT-1];
    logic [ROOT_W-1:0] r_root [SQ_LAT];

    for (genvar k = 0; k < SQ_LAT; k++) begin : g_stage
        logic [A_W-1:0]    w_v;
        logic [ROOT_W-1:0] w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        logic [ROOT_W+1:0] w_rem_s;
        logic [ROOT_W+1:0] w_trial;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_v = i_val;
            assign w_rem_in = '0;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_v = r_v[k-1];
            assign w_rem_in = r_rem[k-1][ROOT_W-1:0];
            assign w_root_in = r_root[k-1];
        end

        assign w_rem_s = {w_rem_in, w_v[A_W-1-2*k -: 2]};
        assign w_trial = {w_root_in, 2'b01};
        assign w_ge = w_rem_s >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= {w_root_in[ROOT_W-2:0], w_ge};
            end
        end

        if (k < SQ_LAT - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v[k] <= w_v;
                    r_rem[k] <= w_ge ? (w_rem_s - w_trial) : w_rem_s;
                end
            end
        end
    end

    assign o_root = r_root[SQ_LAT-1];

endmodule

>>> src/stwsh_lane.sv
`timescale 1ns / 1ps
module stwsh_lane
    import stwsh_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_en,
    input  t_cfg                   i_cfg,
    input  logic [GAIN_W-1:0]      i_gain,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic [SAMPLE_BITS-1:0] o_sample,
    output logic                   o_clip
);

    localparam int SH_UP = (SAMPLE_BITS <= 25) ? 25 - SAMPLE_BITS : 0;
    localparam int SH_DN = (SAMPLE_BITS > 25) ? SAMPLE_BITS - 25 : 0;
    localparam int QTR = TAB_N / 4;
    localparam longint HALFPI_Q30 = 64'd1686629713;
    localparam longint TWO_OVER_RTPI_Q28 = 64'd302896976;
    localparam logic signed [71:0] PRE_LIM = 72'sd1 <<< 36;
    localparam logic signed [71:0] ONE_LIM = 72'sd1 <<< 24;

    // shift-subtract quotient, used only while the tables are built
    function automatic longint unsigned f_udiv(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    function automatic t_rom f_build_sine();
        t_rom tab;
        longint quart [QTR+1];
        longint unsigned x;
        longint unsigned t;
        longint sum;
        longint v;
        int quad;
        int rr;
        for (int j = 0; j <= QTR; j++) begin
            x = longint'(HALFPI_Q30 * j) / QTR;
            t = x;
            sum = longint'(x);
            for (int n = 1; n < 40; n++) begin
                t = (t * x) >> 30;
                t = (t * x) >> 30;
                t = f_udiv(t, longint'((2 * n) * (2 * n + 1)));
                if (t == 0) break;
                if (n % 2 == 1) sum = sum - longint'(t);
                else sum = sum + longint'(t);
            end
            if (sum < 0) sum = 0;
            sum = (sum + 64'sd8192) >>> 14;
            if (sum > 65536) sum = 65536;
            quart[j] = sum;
        end
        for (int k = 0; k < TAB_N; k++) begin
            quad = k / QTR;
            rr = k % QTR;
            v = (quad % 2 == 1) ? quart[QTR - rr] : quart[rr];
            tab[k] = 18'((quad & 2) != 0 ? -v : v);
        end
        return tab;
    endfunction

    function automatic t_rom f_build_erf();
        t_rom tab;
        longint unsigned t;
        longint sum;
        for (int k = 0; k < TAB_N; k++) begin
            t = longint'(k) << (30 - TABLE_BITS);
            sum = longint'(t);
            for (int n = 1; n < 300; n++) begin
                t = (t * longint'(k)) / QTR;
                t = f_udiv(t, longint'(n));
                t = (t * longint'(k)) / QTR;
                if (t == 0) break;
                if (n % 2 == 1) sum = sum - longint'(f_udiv(t, longint'(2 * n + 1)));
                else sum = sum + longint'(f_udiv(t, longint'(2 * n + 1)));
            end
            if (sum < 0) sum = 0;
            sum = (sum * TWO_OVER_RTPI_Q28 + (64'sd1 <<< 39)) >>> 40;
            if (sum > 65536) sum = 65536;
            tab[k] = 18'(sum);
        end
        return tab;
    endfunction

    function automatic logic signed [71:0] f_trunc(input logic signed [71:0] x,
                                                   input logic [4:0] sh);
        logic signed [71:0] bias;
        bias = x[71] ? ((72'sd1 <<< sh) - 72'sd1) : 72'sd0;
        return (x + bias) >>> sh;
    endfunction

    localparam t_rom SINE_ROM = f_build_sine();
    localparam t_rom ERF_ROM = f_build_erf();

    typedef struct packed {
        logic [A_W-1:0]     y;
        logic [A_W-1:0]     a;
        logic               neg;
        logic               over;
        logic signed [17:0] sine;
        logic [17:0]        erf_f;
    } t_lane_dl;

    logic [24:0] w_t24;
    assign w_t24 = {i_cfg.threshold_level, 8'b0};

    // input scaling
    logic w_neg;
    logic [SAMPLE_BITS-1:0] w_mag_in;
    logic [56:0] w_mwide;
    logic [24:0] w_m24;
    logic [40:0] w_aprod;
    logic r1_neg;
    logic [A_W-1:0] r1_a;

    assign w_neg = i_sample[SAMPLE_BITS-1];
    assign w_mag_in = w_neg ? (~i_sample + 1'b1) : i_sample;
    assign w_mwide = (57'(w_mag_in) << SH_UP) >> SH_DN;
    assign w_m24 = w_mwide[24:0];
    assign w_aprod = 41'(w_m24) * 41'(i_cfg.input_gain);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_neg <= w_neg;
            r1_a <= w_aprod[39:12];
        end
    end

    // threshold split
    logic r2_neg, r2_over;
    logic [A_W-1:0] r2_a, r2_y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_neg <= r1_neg;
            r2_over <= r1_a > 28'(w_t24);
            r2_a <= r1_a;
            r2_y <= r1_a - 28'(w_t24);
        end
    end

    // table reads and alignment with the root pipeline
    logic [TABLE_BITS-1:0] w_sidx, w_eidx;
    logic [2:0] w_ehi;
    logic [ROOT_W-1:0] w_root;
    t_lane_dl r_dl [SQ_LAT];

    assign w_sidx = r2_y[26-TABLE_BITS +: TABLE_BITS];
    assign w_eidx = r2_y[25-TABLE_BITS +: TABLE_BITS];
    assign w_ehi = r2_y[A_W-1:25] != '0 ? 3'd1 : 3'd0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dl[0].y <= r2_y;
            r_dl[0].a <= r2_a;
            r_dl[0].neg <= r2_neg;
            r_dl[0].over <= r2_over;
            r_dl[0].sine <= SINE_ROM[w_sidx];
            r_dl[0].erf_f <= (w_ehi != 3'd0) ? 18'd98304
                           : 18'd65536 + 18'($unsigned(ERF_ROM[w_eidx]) >> 1);
            for (int i = 1; i < SQ_LAT; i++) begin
                r_dl[i] <= r_dl[i-1];
            end
        end
    end

    stwsh_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_val  (r2_y),
        .o_root (w_root)
    );

    // first shaping product
    t_lane_dl w_al;
    logic signed [30:0] w_f;
    logic [4:0] w_sh;
    logic signed [59:0] w_p;
    logic signed [35:0] r3_p;
    logic [A_W-1:0] r3_y, r3_a;
    logic r3_neg, r3_over;

    assign w_al = r_dl[SQ_LAT-1];

    always_comb begin
        case (i_cfg.shape_mode)
            MODE_QUAD: begin
                w_f = 31'sd33554432 - $signed({3'b0, w_al.y});
                w_sh = 5'd24;
            end
            MODE_SQRT: begin
                w_f = $signed({17'b0, w_root});
                w_sh = 5'd12;
            end
            MODE_SINE: begin
                w_f = 31'(w_al.sine);
                w_sh = 5'd16;
            end
            MODE_ERF: begin
                w_f = $signed({13'b0, w_al.erf_f});
                w_sh = 5'd16;
            end
            default: begin
                w_f = 31'sd1;
                w_sh = 5'd0;
            end
        endcase
    end

    assign w_p = $signed({1'b0, w_al.y}) * w_f;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_p <= 36'(f_trunc(72'(w_p), w_sh));
            r3_y <= w_al.y;
            r3_a <= w_al.a;
            r3_neg <= w_al.neg;
            r3_over <= w_al.over;
        end
    end

    // ratio and threshold add-back
    logic signed [52:0] w_q;
    logic signed [41:0] w_ex;
    logic [A_W-1:0] w_rlim, w_ex0;
    logic signed [42:0] r4_val;
    logic r4_neg;

    assign w_q = r3_p * $signed({1'b0, i_cfg.ratio_level});
    assign w_rlim = {i_cfg.ratio_level, 12'b0};
    assign w_ex0 = (r3_y > w_rlim) ? w_rlim : r3_y;
    assign w_ex = (i_cfg.shape_mode == MODE_CLIP) ? $signed({14'b0, w_ex0})
                                                  : 42'(f_trunc(72'(w_q), 5'd12));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_val <= r3_over ? ($signed({18'b0, w_t24}) + 43'(w_ex)) : $signed({15'b0, r3_a});
            r4_neg <= r3_neg;
        end
    end

    // boost
    logic signed [59:0] w_bp;
    logic signed [71:0] w_b;
    logic signed [37:0] r5_w;
    logic r5_neg, r5_clip;

    assign w_bp = r4_val * $signed({1'b0, i_cfg.boost_gain});
    assign w_b = f_trunc(72'(w_bp), 5'd12);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_b > PRE_LIM) r5_w <= 38'(PRE_LIM);
            else if (w_b < -PRE_LIM) r5_w <= 38'(-PRE_LIM);
            else r5_w <= 38'(w_b);
            r5_clip <= (72'(r4_val) > ONE_LIM) || (72'(r4_val) < -ONE_LIM);
            r5_neg <= r4_neg;
        end
    end

    // makeup gain and clamp
    logic signed [65:0] w_gp;
    logic signed [71:0] w_g;
    logic signed [25:0] r6_w;
    logic r6_neg, r6_clip;

    assign w_gp = r5_w * $signed({1'b0, i_gain});
    assign w_g = f_trunc(72'(w_gp), 5'd12);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_g > ONE_LIM) r6_w <= 26'(ONE_LIM);
            else if (w_g < -ONE_LIM) r6_w <= 26'(-ONE_LIM);
            else r6_w <= 26'(w_g);
            r6_clip <= r5_clip;
            r6_neg <= r5_neg;
        end
    end

    // output gain, sign restore, saturation
    logic signed [42:0] w_op;
    logic signed [32:0] w_o, w_fin;
    logic w_oneg;
    logic [32:0] w_abs;
    logic [39:0] w_msc, w_lim, w_sat, w_res;
    logic [SAMPLE_BITS-1:0] r7_out;
    logic r7_clip;

    assign w_op = r6_w * $signed({1'b0, i_cfg.output_gain});
    assign w_o = 33'(f_trunc(72'(w_op), 5'd12));
    assign w_fin = r6_neg ? -w_o : w_o;
    assign w_oneg = w_fin[32];
    assign w_abs = w_oneg ? 33'(-w_fin) : 33'(w_fin);
    assign w_msc = (40'(w_abs) >> SH_UP) << SH_DN;
    assign w_lim = (40'd1 << (SAMPLE_BITS - 1)) - (w_oneg ? 40'd0 : 40'd1);
    assign w_sat = (w_msc > w_lim) ? w_lim : w_msc;
    assign w_res = w_oneg ? (~w_sat + 40'd1) : w_sat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_out <= w_res[SAMPLE_BITS-1:0];
            r7_clip <= r6_clip;
        end
    end

    assign o_sample = r7_out;
    assign o_clip = r7_clip;

endmodule

>>> src/stereo_threshold_waveshaper.sv
`timescale 1ns / 1ps
// Stereo threshold waveshaper. Takes one stereo frame per clock unless the output stalls or
// the makeup-gain divider is busy, and presents its result on m_axis from an output register
// behind the channel lanes; the lane depth is set by the pipelined square-root unit in each
// lane plus the scaling and multiplier stages around it. Any configuration write starts the
// makeup-gain divider, which resolves one quotient bit per cycle; s_axis_tready stays low
// while it runs, through the prepare state and, unless threshold and ratio make the gain
// trivial, the division state. A result held on a stalled output lets new frames keep
// entering until a result reaches the last lane stage; the pipeline then holds.
`include "assert_macros.svh"
module stereo_threshold_waveshaper
    import stwsh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // left_in, right_in
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // left_out, right_out
    output logic              m_axis_tuser,   // clip_seen
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [16:0]       i_cfg_data
);

    t_cfg r_cfg;
    logic w_cfg_we, w_busy, w_en, w_accept;
    logic [GAIN_W-1:0] w_gain;
    logic [LANE_LAT-1:0] r_vld;
    logic [SAMPLE_BITS-1:0] w_left, w_right;
    logic w_clip_l, w_clip_r;
    logic r_out_valid, r_out_clip;
    logic [SAMPLE_BITS-1:0] r_out_l, r_out_r;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.input_gain <= 16'd4096;
            r_cfg.threshold_level <= 17'd65536;
            r_cfg.ratio_level <= 16'd4096;
            r_cfg.shape_mode <= MODE_LINEAR;
            r_cfg.boost_gain <= 16'd4096;
            r_cfg.output_gain <= 16'd4096;
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                REG_INPUT_GAIN: r_cfg.input_gain <= i_cfg_data[15:0];
                REG_THRESHOLD: r_cfg.threshold_level <= i_cfg_data;
                REG_RATIO: r_cfg.ratio_level <= i_cfg_data[15:0];
                REG_SHAPE_MODE: r_cfg.shape_mode <= i_cfg_data[2:0];
                REG_BOOST_GAIN: r_cfg.boost_gain <= i_cfg_data[15:0];
                REG_OUTPUT_GAIN: r_cfg.output_gain <= i_cfg_data[15:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    stwsh_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_we    (w_cfg_we),
        .o_busy  (w_busy),
        .o_gain  (w_gain)
    );

    // hold only when the output is blocked and a result is ready behind it
    assign w_en = !(r_out_valid && !m_axis_tready && r_vld[LANE_LAT-1]);
    assign s_axis_tready = w_en && !w_busy;
    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LANE_LAT-2:0], w_accept};
        end
    end

    stwsh_lane u_lane_l (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_cfg    (r_cfg),
        .i_gain   (w_gain),
        .i_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_sample (w_left),
        .o_clip   (w_clip_l)
    );

    stwsh_lane u_lane_r (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_cfg    (r_cfg),
        .i_gain   (w_gain),
        .i_sample (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .o_sample (w_right),
        .o_clip   (w_clip_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en && r_vld[LANE_LAT-1]) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_vld[LANE_LAT-1]) begin
            r_out_l <= w_left;
            r_out_r <= w_right;
            r_out_clip <= w_clip_l || w_clip_r;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = DATA_W'({r_out_r, r_out_l});
    assign m_axis_tuser = r_out_clip;

    `ASSERT_NEXT(a_cfg_blocks_input, w_cfg_we, !s_axis_tready, "frame taken while makeup gain recomputes")
    `ASSERT_NEXT(a_transfer_enters, w_accept, r_vld[0], "accepted frame missing from pipeline")

endmodule
